// ===== sv/bpa_pkg.sv =====
`default_nettype none
package bpa_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUPPLY_W = 13;
   localparam int P0_W     = 17;
   localparam int PRESS_W  = 18;
   localparam int ALT_W    = 20;
   localparam int RATIO_W  = 19;

   localparam logic [PRESS_W-1:0] PRESS_MAX = 18'd262143;
   localparam logic [RATIO_W-1:0] RATIO_MAX = 19'd262144;
   localparam logic [P0_W-1:0]    P0_RESET  = 17'd101960;

   // Status of the pressure numerator, carried alongside the reciprocal multiply.
   typedef struct packed {
      logic neg;
      logic sat;
   } bpa_front_side_type;

   // Pressure result and status, carried alongside the ratio divider.
   typedef struct packed {
      logic [PRESS_W-1:0] press;
      logic               flag;
      logic               ovf;
   } bpa_ratio_side_type;

endpackage
`default_nettype wire

// ===== sv/bpa_div.sv =====
`default_nettype none
module bpa_div #(
   parameter int DW  = 28,
   parameter int QW  = 18,
   parameter int BPS = 3,
   parameter int SW  = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [DW+QW-1:0]    in_num,
   input  wire logic [DW-1:0]       in_den,
   input  wire logic [SW-1:0]       in_side,
   output logic                     out_valid,
   output logic [QW-1:0]            out_quot,
   output logic [SW-1:0]            out_side
);

   localparam int NW     = DW + QW;
   localparam int STAGES = (QW + BPS - 1) / BPS;

   logic [STAGES-1:0] valid_ff;
   logic [NW-1:0]     rem_ff  [STAGES];
   logic [QW-1:0]     quot_ff [STAGES];
   logic [DW-1:0]     den_ff  [STAGES];
   logic [SW-1:0]     side_ff [STAGES];

   // Restoring division: each stage settles BPS quotient bits, most significant first.
   for (genvar st = 0; st < STAGES; st++) begin : g_stage
      logic          valid_in;
      logic [NW-1:0] rem_prev;
      logic [QW-1:0] quot_prev;
      logic [NW-1:0] rem_in;
      logic [QW-1:0] quot_in;
      logic [DW-1:0] den_in;
      logic [SW-1:0] side_in;

      if (st == 0) begin : g_first
         assign valid_in  = in_valid;
         assign rem_prev  = in_num;
         assign quot_prev = '0;
         assign den_in    = in_den;
         assign side_in   = in_side;
      end else begin : g_next
         assign valid_in  = valid_ff[st-1];
         assign rem_prev  = rem_ff[st-1];
         assign quot_prev = quot_ff[st-1];
         assign den_in    = den_ff[st-1];
         assign side_in   = side_ff[st-1];
      end

      always_comb begin
         int b;
         logic [NW-1:0] trial;
         rem_in  = rem_prev;
         quot_in = quot_prev;
         for (int j = 0; j < BPS; j++) begin
            b = QW - 1 - st * BPS - j;
            if (b >= 0) begin
               trial = NW'(den_in) << b;
               if (rem_in >= trial) begin
                  rem_in     = rem_in - trial;
                  quot_in[b] = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[st] <= 1'b0;
         end else begin
            valid_ff[st] <= valid_in;
         end
         rem_ff[st]  <= rem_in;
         quot_ff[st] <= quot_in;
         den_ff[st]  <= den_in;
         side_ff[st] <= side_in;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quot  = quot_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule
`default_nettype wire

// ===== sv/bpa_front.sv =====
`default_nettype none
module bpa_front #(
   parameter int ADC_FULL_SCALE = 32767,
   localparam int FW    = $clog2(ADC_FULL_SCALE + 1),
   localparam int DW    = $clog2(18 * ADC_FULL_SCALE + 1),
   localparam int NW    = DW + bpa_pkg::PRESS_W
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic signed [bpa_pkg::SAMPLE_W-1:0] in_adc_sample,
   input  wire logic [bpa_pkg::SUPPLY_W-1:0]  in_supply_mv,
   output logic                               out_valid,
   output logic [bpa_pkg::PRESS_W-1:0]        out_quot,
   output bpa_pkg::bpa_front_side_type        out_side
);

   localparam int NUM_W = (FW + 22 > 38) ? FW + 22 : 38;
   localparam int X_W   = NUM_W + 1;
   localparam logic signed [NUM_W-1:0] FS     = NUM_W'(ADC_FULL_SCALE);
   localparam logic [X_W-1:0]          DEN9   = X_W'(9 * ADC_FULL_SCALE);
   localparam logic [X_W-1:0]          DEN18  = X_W'(18 * ADC_FULL_SCALE);

   // The reciprocal of 18 times full scale, rounded up, with a shift of NW + DW bits.
   // The error it adds stays below one part in 2^DW of the quotient, so the
   // truncated product is the exact floor for every numerator below 2^NW.
   localparam int S_W  = NW + DW;
   localparam int H_X  = NW / 2;
   localparam int H_M  = (NW + 1) / 2;
   localparam int XA_W = NW - H_X;
   localparam int MA_W = NW + 1 - H_M;
   localparam int P_W  = 2 * NW + 1;
   localparam logic [S_W:0]    POW_S    = (S_W+1)'(1) << S_W;
   localparam logic [S_W:0]    DEN_S    = (S_W+1)'(18 * ADC_FULL_SCALE);
   localparam logic [S_W:0]    RECIP_S  = (POW_S + DEN_S - (S_W+1)'(1)) / DEN_S;
   localparam logic [NW:0]     RECIP    = RECIP_S[NW:0];
   localparam logic [MA_W-1:0] RECIP_HI = RECIP[NW:H_M];
   localparam logic [H_M-1:0]  RECIP_LO = RECIP[H_M-1:0];

   logic [4:0] valid_ff;

   // Stage one: sample times supply, and the supply correction term.
   logic signed [29:0] sv_ff, sv_in;
   logic signed [21:0] term_ff, term_in;

   assign sv_in   = 30'(in_adc_sample) * $signed({1'b0, in_supply_mv});
   // 83*(9997 - 2v) + 91400 folds to 921151 - 166v.
   assign term_in = 22'sd921151 - 22'sd166 * $signed({9'b0, in_supply_mv});

   // Stage two: scale both terms.
   logic signed [NUM_W-1:0] pa_ff, pa_in, pb_ff, pb_in;

   assign pa_in = NUM_W'(term_ff) * FS;
   assign pb_in = NUM_W'(sv_ff) * NUM_W'(200);

   // Stage three: sum, rounding offset and the saturation test.
   logic signed [NUM_W-1:0]     num_c;
   logic [X_W-1:0]              x_c;
   logic                        neg_c, sat_c;
   logic [NW-1:0]               num_ff, num_in;
   bpa_pkg::bpa_front_side_type side_ff, side_in;

   always_comb begin
      num_c   = pa_ff + pb_ff;
      neg_c   = num_c[NUM_W-1];
      x_c     = {num_c[NUM_W-1:0], 1'b0} + DEN9;
      sat_c   = !neg_c && ((x_c >> bpa_pkg::PRESS_W) >= DEN18);
      num_in  = (neg_c || sat_c) ? '0 : x_c[NW-1:0];
      side_in = '{neg: neg_c, sat: sat_c};
   end

   // Stage four: the four partial products of numerator times reciprocal.
   logic [XA_W+MA_W-1:0]        pp_hh_ff, pp_hh_in;
   logic [XA_W+H_M-1:0]         pp_hl_ff, pp_hl_in;
   logic [H_X+MA_W-1:0]         pp_lh_ff, pp_lh_in;
   logic [H_X+H_M-1:0]          pp_ll_ff, pp_ll_in;
   bpa_pkg::bpa_front_side_type side_mul_ff;

   assign pp_hh_in = (XA_W+MA_W)'(num_ff[NW-1:H_X]) * (XA_W+MA_W)'(RECIP_HI);
   assign pp_hl_in = (XA_W+H_M)'(num_ff[NW-1:H_X]) * (XA_W+H_M)'(RECIP_LO);
   assign pp_lh_in = (H_X+MA_W)'(num_ff[H_X-1:0]) * (H_X+MA_W)'(RECIP_HI);
   assign pp_ll_in = (H_X+H_M)'(num_ff[H_X-1:0]) * (H_X+H_M)'(RECIP_LO);

   // Stage five: add the partial products and keep the integer part.
   logic [P_W-1:0]                prod_c;
   logic [bpa_pkg::PRESS_W-1:0]   quot_ff, quot_in;
   bpa_pkg::bpa_front_side_type   side_out_ff;

   always_comb begin
      prod_c  = (P_W'(pp_hh_ff) << (H_X + H_M)) + (P_W'(pp_hl_ff) << H_X) +
                (P_W'(pp_lh_ff) << H_M) + P_W'(pp_ll_ff);
      quot_in = prod_c[S_W+bpa_pkg::PRESS_W-1:S_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
      sv_ff       <= sv_in;
      term_ff     <= term_in;
      pa_ff       <= pa_in;
      pb_ff       <= pb_in;
      num_ff      <= num_in;
      side_ff     <= side_in;
      pp_hh_ff    <= pp_hh_in;
      pp_hl_ff    <= pp_hl_in;
      pp_lh_ff    <= pp_lh_in;
      pp_ll_ff    <= pp_ll_in;
      side_mul_ff <= side_ff;
      quot_ff     <= quot_in;
      side_out_ff <= side_mul_ff;
   end

   assign out_valid = valid_ff[4];
   assign out_quot  = quot_ff;
   assign out_side  = side_out_ff;

endmodule
`default_nettype wire

// ===== sv/bpa_pow.sv =====
`default_nettype none
module bpa_pow #(
   parameter int POW_TABLE_SEGMENTS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic [bpa_pkg::RATIO_W-1:0]  in_quot,
   input  wire bpa_pkg::bpa_ratio_side_type  in_side,
   output logic                              out_valid,
   output logic [bpa_pkg::PRESS_W-1:0]       out_pressure_pa,
   output logic signed [bpa_pkg::ALT_W-1:0]  out_altitude_dm,
   output logic                              out_range_flag
);

   localparam int N      = POW_TABLE_SEGMENTS;
   localparam int IW     = $clog2(N + 1);
   localparam int DEPTH  = 8;
   localparam logic [31:0] RECIP25 = 32'd2748779070;

   typedef struct packed {
      logic [bpa_pkg::PRESS_W-1:0] press;
      logic                        flag;
      logic                        zero;
   } pow_side_type;

   // log2 of a Q1.30 value in [1, 2) as Q0.24, by repeated squaring.
   function automatic logic [23:0] log2_q24(input logic [63:0] xin);
      logic [63:0] x;
      logic [23:0] res;
      x   = xin;
      res = '0;
      for (int b = 23; b >= 0; b--) begin
         x = (x * x) >> 30;
         if (x >= 64'h8000_0000) begin
            res[b] = 1'b1;
            x      = x >> 1;
         end
      end
      return res;
   endfunction

   function automatic logic [24:0] log_entry(input int i);
      logic [63:0] num;
      num = 64'(i) << 30;
      if (i == N) begin
         return 25'h100_0000;
      end
      return {1'b0, log2_q24(64'h4000_0000 + num / POW_TABLE_SEGMENTS)};
   endfunction

   function automatic logic [31:0] exp_entry(input int i);
      logic [63:0] target, lo, hi, mid;
      target = (64'(i) << 24) / POW_TABLE_SEGMENTS;
      lo     = 64'h4000_0000;
      hi     = 64'h7FFF_FFFF;
      mid    = lo;
      if (i == 0) begin
         return 32'h4000_0000;
      end
      if (i == N) begin
         return 32'h8000_0000;
      end
      for (int it = 0; it < 32; it++) begin
         if (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (64'(log2_q24(mid)) <= target) begin
               lo = mid;
            end else begin
               hi = mid - 64'd1;
            end
         end
      end
      return lo[31:0];
   endfunction

   logic [24:0] log_tab [0:N];
   logic [31:0] exp_tab [0:N];

   for (genvar g = 0; g <= N; g++) begin : g_tab
      localparam logic [24:0] LV = log_entry(g);
      localparam logic [31:0] EV = exp_entry(g);
      assign log_tab[g] = LV;
      assign exp_tab[g] = EV;
   end

   logic [DEPTH-1:0] valid_ff;
   pow_side_type     side_ff [DEPTH];
   pow_side_type     side_in;

   // Stage one: clamp the ratio, normalise it and find the log table segment.
   logic [bpa_pkg::RATIO_W-1:0] r_c, mw_c;
   logic                        over_c;
   logic [4:0]                  e_c;
   logic [15+IW:0]              pos1_c;
   logic [IW-1:0]               idx1_ff, idx1_in;
   logic [15:0]                 w1_ff, w1_in;
   logic [4:0]                  e1_ff, e2_ff;

   always_comb begin
      over_c = in_quot > bpa_pkg::RATIO_MAX;
      r_c    = (in_side.ovf || over_c) ? bpa_pkg::RATIO_MAX : in_quot;
      e_c    = '0;
      for (int i = 0; i < bpa_pkg::RATIO_W; i++) begin
         if (r_c[i]) begin
            e_c = 5'(i);
         end
      end
      mw_c    = (e_c >= 5'd16) ? (r_c >> (e_c - 5'd16)) : (r_c << (5'd16 - e_c));
      pos1_c  = (16+IW)'(mw_c[15:0]) * (16+IW)'(N);
      idx1_in = pos1_c[15+IW:16];
      w1_in   = pos1_c[15:0];
      side_in = '{press: in_side.press, flag: in_side.flag | in_side.ovf | over_c,
                  zero: (r_c == '0)};
   end

   // Stage two: interpolate the log table.
   logic [24:0] l0_ff, l0_in, lfrac_ff, lfrac_in;
   logic [24:0] ldiff_c;
   logic [40:0] lprod_c;

   always_comb begin
      ldiff_c  = log_tab[idx1_ff + IW'(1)] - log_tab[idx1_ff];
      lprod_c  = 41'(ldiff_c) * 41'(w1_ff);
      l0_in    = log_tab[idx1_ff];
      lfrac_in = lprod_c[40:16];
   end

   // Stage three: add the exponent, scale by 19 and bias so that the
   // division by 100 sees a non-negative value.
   logic signed [5:0]  ex_c;
   logic signed [29:0] lg_c;
   logic signed [35:0] a_c;
   logic [30:0]        b_ff, b_in;

   always_comb begin
      ex_c = $signed({1'b0, e2_ff}) - 6'sd16;
      lg_c = $signed(30'(l0_ff)) + $signed(30'(lfrac_ff)) + (30'(ex_c) <<< 24);
      a_c  = 36'(lg_c) * 36'sd19 + 36'sd6710886400;
      b_in = a_c[32:2];
   end

   // Stage four: divide by 25 with a reciprocal multiply.
   logic [62:0] qprod_c;
   logic [26:0] qd_ff, qd_in;

   assign qprod_c = 63'(b_ff) * 63'(RECIP25);
   assign qd_in   = qprod_c[62:36];

   // Stage five: remove the bias, split into integer and fraction.
   logic signed [27:0] t_c;
   logic signed [3:0]  k_c;
   logic [23+IW:0]     pos2_c;
   logic [IW-1:0]      idx2_ff, idx2_in;
   logic [23:0]        w2_ff, w2_in;
   logic [2:0]         sh_ff, sh_in, sh2_ff;

   always_comb begin
      t_c     = $signed({1'b0, qd_ff}) - 28'sd67108864;
      k_c     = t_c[27:24];
      sh_in   = 3'(-k_c);
      pos2_c  = (24+IW)'(t_c[23:0]) * (24+IW)'(N);
      idx2_in = pos2_c[23+IW:24];
      w2_in   = pos2_c[23:0];
   end

   // Stage six: interpolate the exp table.
   logic [31:0] e0_ff, e0_in, efrac_ff, efrac_in, ediff_c;
   logic [55:0] eprod_c;

   always_comb begin
      ediff_c  = exp_tab[idx2_ff + IW'(1)] - exp_tab[idx2_ff];
      eprod_c  = 56'(ediff_c) * 56'(w2_ff);
      e0_in    = exp_tab[idx2_ff];
      efrac_in = eprod_c[55:24];
   end

   // Stage seven: apply the negative exponent and form one minus the power.
   logic [31:0]        pw_c;
   logic signed [32:0] d_ff, d_in;

   always_comb begin
      pw_c = side_ff[5].zero ? '0 : ((e0_ff + efrac_ff) >> sh2_ff);
      d_in = 33'sd1073741824 - $signed({1'b0, pw_c});
   end

   // Stage eight: scale to decimetres and round.
   logic signed [51:0] alt_c;
   logic signed [bpa_pkg::ALT_W-1:0] alt_ff, alt_in;

   assign alt_c  = 52'(d_ff) * 52'sd443300 + 52'sd536870912;
   assign alt_in = alt_c[30+bpa_pkg::ALT_W-1:30];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DEPTH-2:0], in_valid};
      end
      side_ff[0] <= side_in;
      for (int i = 1; i < DEPTH; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
      idx1_ff  <= idx1_in;
      w1_ff    <= w1_in;
      e1_ff    <= e_c;
      l0_ff    <= l0_in;
      lfrac_ff <= lfrac_in;
      e2_ff    <= e1_ff;
      b_ff     <= b_in;
      qd_ff    <= qd_in;
      idx2_ff  <= idx2_in;
      w2_ff    <= w2_in;
      sh_ff    <= sh_in;
      e0_ff    <= e0_in;
      efrac_ff <= efrac_in;
      sh2_ff   <= sh_ff;
      d_ff     <= d_in;
      alt_ff   <= alt_in;
   end

   assign out_valid       = valid_ff[DEPTH-1];
   assign out_pressure_pa = side_ff[DEPTH-1].press;
   assign out_range_flag  = side_ff[DEPTH-1].flag;
   assign out_altitude_dm = alt_ff;

endmodule
`default_nettype wire

// ===== sv/baro_pressure_altitude_core.sv =====
// Barometric altitude core. Each request carries a signed converter sample and the
// supply voltage in millivolts; the core returns pressure in pascals, altitude in
// decimetres relative to the programmed sea-level pressure, and a range flag. The
// core is a straight pipeline with no state between requests: busy never rises, so
// a request may be issued on every cycle, and each result is on the rsp_ ports for
// exactly one cycle, marked by rsp_strobe. The pipeline forms the pressure (sample
// product, scaling, rounding offset and range test, then a reciprocal multiplication
// by one over 18 times full scale, split into partial products and their sum), then
// the ratio numerator, then runs the ratio divider (four quotient bits a cycle) and
// the power evaluation and altitude scaling. Results leave in request order and the
// receiver cannot hold them off. The sea-level pressure register is written through
// the csr_ channel, which is always ready; it must only be written while no request
// is in flight, and it resets to 101960 Pa.
`default_nettype none
module baro_pressure_altitude_core #(
   parameter int ADC_FULL_SCALE     = 32767,
   parameter int POW_TABLE_SEGMENTS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic signed [bpa_pkg::SAMPLE_W-1:0] req_adc_sample,
   input  wire logic [bpa_pkg::SUPPLY_W-1:0]        req_supply_mv,
   output logic                                     rsp_strobe,
   output logic [bpa_pkg::PRESS_W-1:0]              rsp_pressure_pa,
   output logic signed [bpa_pkg::ALT_W-1:0]         rsp_altitude_dm,
   output logic                                     rsp_range_flag,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bpa_pkg::P0_W-1:0]            csr_data
);

   // Ratio divider: rounded ratio = (P*2^17 + P0) / 2*P0.
   localparam int DW2 = bpa_pkg::P0_W + 1;
   localparam int NW2 = DW2 + bpa_pkg::RATIO_W;

   // The pipeline never stalls, so every request is taken the cycle it is issued.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   logic [bpa_pkg::P0_W-1:0] p0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_ff <= bpa_pkg::P0_RESET;
      end else if (csr_valid && csr_ready) begin
         p0_ff <= csr_data;
      end
   end

   // Rounded pressure from the sensor transfer function, with the negative and
   // overflow cases picked out alongside it.
   logic                        front_valid;
   logic [bpa_pkg::PRESS_W-1:0] front_quot;
   bpa_pkg::bpa_front_side_type front_side;

   bpa_front #(
      .ADC_FULL_SCALE(ADC_FULL_SCALE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start && !busy),
      .in_adc_sample (req_adc_sample),
      .in_supply_mv  (req_supply_mv),
      .out_valid     (front_valid),
      .out_quot      (front_quot),
      .out_side      (front_side)
   );

   // Resolve the pressure, then set up the ratio division. A ratio of eight or
   // more (or a zero reference) is caught here, since the divider only settles
   // quotients below 2^19.
   logic [bpa_pkg::PRESS_W-1:0] press_c;
   logic [NW2-1:0]              y_c;
   logic [DW2-1:0]              den2_c;
   logic                        ovf_c;

   logic                        ratio_valid_ff;
   logic [NW2-1:0]              num2_ff, num2_in;
   logic [DW2-1:0]              den2_ff;
   bpa_pkg::bpa_ratio_side_type side2_ff, side2_in;

   always_comb begin
      if (front_side.neg) begin
         press_c = '0;
      end else if (front_side.sat) begin
         press_c = bpa_pkg::PRESS_MAX;
      end else begin
         press_c = front_quot;
      end
      y_c      = NW2'({press_c, 17'b0}) + NW2'(p0_ff);
      den2_c   = {p0_ff, 1'b0};
      ovf_c    = (p0_ff == '0) || (y_c[NW2-1:bpa_pkg::RATIO_W] >= den2_c);
      num2_in  = ovf_c ? '0 : y_c;
      side2_in = '{press: press_c, flag: front_side.neg | front_side.sat, ovf: ovf_c};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_valid_ff <= 1'b0;
      end else begin
         ratio_valid_ff <= front_valid;
      end
      num2_ff  <= num2_in;
      den2_ff  <= den2_c;
      side2_ff <= side2_in;
   end

   logic                        div2_valid;
   logic [bpa_pkg::RATIO_W-1:0] div2_quot;
   bpa_pkg::bpa_ratio_side_type div2_side;

   bpa_div #(
      .DW  (DW2),
      .QW  (bpa_pkg::RATIO_W),
      .BPS (4),
      .SW  ($bits(bpa_pkg::bpa_ratio_side_type))
   ) u_div_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ratio_valid_ff),
      .in_num    (num2_ff),
      .in_den    (den2_ff),
      .in_side   (side2_ff),
      .out_valid (div2_valid),
      .out_quot  (div2_quot),
      .out_side  (div2_side)
   );

   // Ratio to the power 0.19 through log2 and exp2 tables, then altitude.
   bpa_pow #(
      .POW_TABLE_SEGMENTS(POW_TABLE_SEGMENTS)
   ) u_pow (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (div2_valid),
      .in_quot         (div2_quot),
      .in_side         (div2_side),
      .out_valid       (rsp_strobe),
      .out_pressure_pa (rsp_pressure_pa),
      .out_altitude_dm (rsp_altitude_dm),
      .out_range_flag  (rsp_range_flag)
   );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Every request carries one converter sample and one supply reading. Each
   // accepted request is run through a fixed-point predictor, and the predicted
   // pressure, altitude and range flag are queued. Results leave in request
   // order, so each strobed result is compared with the oldest prediction.

   localparam int FULL_SCALE = 32767;
   localparam int SEGMENTS   = 64;
   localparam longint Q30    = 64'd1073741824;
   localparam longint Q24    = 64'd16777216;
   localparam int SETTLE     = 40;
   localparam longint CYCLE_LIMIT = 200000;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic signed [bpa_pkg::SAMPLE_W-1:0] req_adc_sample;
   logic [bpa_pkg::SUPPLY_W-1:0]        req_supply_mv;
   logic                                rsp_strobe;
   logic [bpa_pkg::PRESS_W-1:0]         rsp_pressure_pa;
   logic signed [bpa_pkg::ALT_W-1:0]    rsp_altitude_dm;
   logic                                rsp_range_flag;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [bpa_pkg::P0_W-1:0]            csr_data;

   typedef struct {
      logic [bpa_pkg::PRESS_W-1:0] press;
      logic [bpa_pkg::ALT_W-1:0]   alt;
      logic                        flag;
   } altitude_result_type;

   altitude_result_type      pending_altitudes[$];
   longint unsigned          log2_table[SEGMENTS+1];
   longint unsigned          exp2_table[SEGMENTS+1];
   logic [bpa_pkg::P0_W-1:0] sea_level_pa;
   int                       mismatch_count;
   longint                   cycle_count;

   baro_pressure_altitude_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_adc_sample  (req_adc_sample),
      .req_supply_mv   (req_supply_mv),
      .rsp_strobe      (rsp_strobe),
      .rsp_pressure_pa (rsp_pressure_pa),
      .rsp_altitude_dm (rsp_altitude_dm),
      .rsp_range_flag  (rsp_range_flag),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // The log2 of a Q1.30 value, returned in Q0.24. Each result bit is found by
   // squaring the value and checking whether the square has reached two.
   function automatic longint unsigned log2_fraction(longint unsigned x);
      longint unsigned acc;
      acc = 0;
      for (int b = 23; b >= 0; b--) begin
         x = (x * x) >> 30;
         if (x >= 2 * Q30) begin
            acc |= 64'd1 << b;
            x >>= 1;
         end
      end
      return acc;
   endfunction

   // Builds both interpolation tables. Each exp2 entry is the largest mantissa
   // whose log2 does not exceed the target, and it is found by bisection.
   function automatic void build_power_tables();
      longint unsigned target, lo, hi, mid;
      for (int i = 0; i < SEGMENTS; i++)
         log2_table[i] = log2_fraction(Q30 + ((longint'(i) << 30) / SEGMENTS));
      log2_table[SEGMENTS] = Q24;
      exp2_table[0] = Q30;
      for (int i = 1; i < SEGMENTS; i++) begin
         target = (longint'(i) << 24) / SEGMENTS;
         lo = Q30;
         hi = 2 * Q30 - 1;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (log2_fraction(mid) <= target) lo = mid;
            else hi = mid - 1;
         end
         exp2_table[i] = lo;
      end
      exp2_table[SEGMENTS] = 2 * Q30;
   endfunction

   function automatic longint floor_quotient(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   // Raises a Q3.16 ratio to the power 0.19 and returns the result in Q.30.
   // The power is worked out as exp2 of 0.19 times log2 of the ratio.
   function automatic longint unsigned ratio_power(longint unsigned r);
      int              e, k;
      longint unsigned m, pos, idx, w, ev;
      longint          lg, t, f;
      e = 0;
      while (e < 62 && (r >> (e + 1)) != 0) e++;
      m = (e >= 16) ? (r >> (e - 16)) : (r << (16 - e));
      pos = (m - 65536) * SEGMENTS;
      idx = pos >> 16;
      w = pos & 64'hFFFF;
      if (idx >= SEGMENTS) begin
         idx = SEGMENTS - 1;
         w = 64'hFFFF;
      end
      lg = longint'(log2_table[idx] +
                    (((log2_table[idx+1] - log2_table[idx]) * w) >> 16));
      lg += longint'(e - 16) * Q24;
      t = floor_quotient(lg * 19, 100);
      k = int'(floor_quotient(t, Q24));
      f = t - longint'(k) * Q24;
      pos = longint'(f) * SEGMENTS;
      idx = pos >> 24;
      w = pos & 64'hFFFFFF;
      if (idx >= SEGMENTS) begin
         idx = SEGMENTS - 1;
         w = 64'hFFFFFF;
      end
      ev = exp2_table[idx] + (((exp2_table[idx+1] - exp2_table[idx]) * w) >> 24);
      if (k >= 0) return ev << ((k > 2) ? 2 : k);
      if (-k > 62) return 0;
      return ev >> (-k);
   endfunction

   // Predicts the result of one request under the current sea-level pressure.
   function automatic altitude_result_type predict_altitude(
         logic signed [bpa_pkg::SAMPLE_W-1:0] sample,
         logic [bpa_pkg::SUPPLY_W-1:0]        supply);
      altitude_result_type res;
      longint              s, v, num, den, press, alt;
      longint unsigned     p0, r, pw;
      logic                flag;
      flag = 1'b0;
      s = longint'(sample);
      v = longint'(supply);
      num = 200 * s * v + longint'(FULL_SCALE) * (83 * (9997 - 2 * v) + 91400);
      den = 9 * longint'(FULL_SCALE);
      if (num < 0) begin
         press = 0;
         flag = 1'b1;
      end else begin
         press = (2 * num + den) / (2 * den);
         if (press > 262143) begin
            press = 262143;
            flag = 1'b1;
         end
      end
      p0 = sea_level_pa;
      if (p0 == 0) begin
         r = 262144;
         flag = 1'b1;
      end else begin
         r = (longint'(press) * 131072 + p0) / (2 * p0);
         if (r > 262144) begin
            r = 262144;
            flag = 1'b1;
         end
      end
      pw = (r == 0) ? 0 : ratio_power(r);
      alt = floor_quotient(443300 * (Q30 - longint'(pw)) + Q30 / 2, Q30);
      res.press = press[bpa_pkg::PRESS_W-1:0];
      res.alt = alt[bpa_pkg::ALT_W-1:0];
      res.flag = flag;
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // Compares each strobed result with the oldest prediction still waiting.
   always @(posedge clock) begin
      altitude_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_altitudes.size() == 0) begin
            report_mismatch("result count (unexpected result)", 1, 0);
         end else begin
            want = pending_altitudes.pop_front();
            if (rsp_pressure_pa !== want.press)
               report_mismatch("pressure_pa", rsp_pressure_pa, want.press);
            if (rsp_altitude_dm !== want.alt)
               report_mismatch("altitude_dm", rsp_altitude_dm, $signed(want.alt));
            if (rsp_range_flag !== want.flag)
               report_mismatch("range_flag", rsp_range_flag, want.flag);
         end
      end
   end

   // Guards against a hang. The limit is far above the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[baro_pressure_altitude_core] ERROR");
         $finish;
      end
   end

   // Issues one request after a random gap. Start stays high between
   // back-to-back requests and only drops when a gap is drawn.
   task automatic send_request(logic signed [bpa_pkg::SAMPLE_W-1:0] sample,
                               logic [bpa_pkg::SUPPLY_W-1:0] supply);
      int gap;
      gap = int'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_adc_sample <= sample;
      req_supply_mv <= supply;
      do @(posedge clock); while (busy);
      pending_altitudes.push_back(predict_altitude(sample, supply));
   endtask

   // Drops start and waits until every result has arrived, then lets the
   // pipeline settle for a little longer.
   task automatic drain_pipeline();
      start <= 1'b0;
      while (pending_altitudes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes the sea-level pressure register. This is only done while no
   // request is in flight.
   task automatic write_sea_level(logic [bpa_pkg::P0_W-1:0] value);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sea_level_pa = value;
   endtask

   task automatic send_random_request();
      logic signed [bpa_pkg::SAMPLE_W-1:0] sample;
      logic [bpa_pkg::SUPPLY_W-1:0]        supply;
      if ($urandom_range(0, 2) != 0) begin
         // This keeps the readings in the sensor's realistic operating region.
         sample = 16'($urandom_range(0, 32767));
         supply = 13'($urandom_range(4300, 5600));
      end else begin
         sample = 16'($urandom);
         supply = 13'($urandom);
      end
      send_request(sample, supply);
   endtask

   // These cover the extremes of both fields and the point where pressure
   // turns negative.
   task automatic test_field_extremes();
      send_request(16'sh7FFF, 13'd0);
      send_request(16'sh8000, 13'd0);
      send_request(16'sh7FFF, 13'd8191);
      send_request(16'sh8000, 13'd8191);
      send_request(16'sh0000, 13'd5000);
      send_request(16'shFFFF, 13'd5000);
      send_request(16'sh8000, 13'd6000);
      send_request(16'sh4000, 13'd5000);
      send_request(16'sh2000, 13'd4500);
      send_request(-16'sd2600, 13'd5000);
      send_request(16'sh5555, 13'h0AAA);
      send_request(16'shAAAA, 13'h1555);
      drain_pipeline();
   endtask

   // A low reference pressure forces the ratio clamp. A zero reference takes
   // the ratio straight to four. A negative pressure gives a zero ratio.
   task automatic test_ratio_clamp();
      write_sea_level(17'd30000);
      send_request(16'sh7FFF, 13'd8191);
      send_request(16'sh7FFF, 13'd5000);
      send_request(16'sh1000, 13'd5000);
      send_request(16'sh8000, 13'd8191);
      write_sea_level(17'd0);
      send_request(16'sh4000, 13'd5000);
      send_request(16'sh8000, 13'd8191);
      write_sea_level(17'h1FFFF);
      send_request(16'sh7FFF, 13'd8191);
      send_request(16'sh0100, 13'd5000);
      drain_pipeline();
   endtask

   // Random requests at several reference pressures, including the default.
   task automatic test_random_requests();
      logic [bpa_pkg::P0_W-1:0] settings[6];
      settings = '{17'd101960, 17'd30000, 17'd120000, 17'd1, 17'd131071, 17'd0};
      foreach (settings[i]) begin
         write_sea_level(settings[i]);
         repeat (200) send_random_request();
      end
      for (int i = 0; i < 3; i++) begin
         write_sea_level(17'($urandom_range(30000, 120000)));
         repeat (75) send_random_request();
      end
      drain_pipeline();
   endtask

   initial begin
      start = 1'b0;
      req_adc_sample = '0;
      req_supply_mv = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      sea_level_pa = bpa_pkg::P0_RESET;
      build_power_tables();
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_ratio_clamp();
      test_random_requests();

      if (mismatch_count == 0) begin
         $display("[baro_pressure_altitude_core] OK");
      end else begin
         $display("[baro_pressure_altitude_core] ERROR");
      end
      $finish;
   end

endmodule
